/* rtl/xorshift_star_prng_assert.svh */
// ---------------------------------------------------------------------------
// xorshift_star_prng_assert.svh
// assertion macros shared by the generator rtl; clk and rst_n are implied
// ---------------------------------------------------------------------------
`ifndef XORSHIFT_STAR_PRNG_ASSERT_SVH
`define XORSHIFT_STAR_PRNG_ASSERT_SVH

// same-cycle implication, disabled during reset
`define XSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define XSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/xsp_pkg.sv */
// ---------------------------------------------------------------------------
// xsp_pkg
// constants, codes and default seed table of the xorshift-star generator
// ---------------------------------------------------------------------------
package xsp_pkg;

    // store geometry
    localparam int STORE_WORDS = 64;
    localparam int TABLE_WORDS = 64;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int SMALL_W     = 4;
    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;

    // input opcodes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_SMALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_LARGE = 2'd2;

    // variant codes
    localparam logic VAR_SMALL = 1'b0;
    localparam logic VAR_LARGE = 1'b1;

    // register reset values
    localparam logic [WORD_W-1:0] MULT_SMALL_RST = 64'd1181783497276652981;
    localparam logic [WORD_W-1:0] MULT_LARGE_RST = 64'd8372773778140471301;

    // shift amounts of the two generators
    localparam int SMALL_A = 31;
    localparam int SMALL_B = 11;
    localparam int SMALL_C = 30;
    localparam int LARGE_A = 25;
    localparam int LARGE_B = 3;
    localparam int LARGE_C = 49;

    // store contents after reset
    localparam logic [WORD_W-1:0] DEFAULT_SEEDS [TABLE_WORDS] = '{
        64'd396211266, 64'd318936545, 64'd239782012, 64'd327524388,
        64'd262111400, 64'd138645947, 64'd129773377, 64'd388466163,
        64'd112746286, 64'd213523003, 64'd275358881, 64'd282949203,
        64'd178572974, 64'd90135547,  64'd421770271, 64'd303986047,
        64'd309203197, 64'd255247428, 64'd268867007, 64'd318765536,
        64'd304687789, 64'd405614684, 64'd269760794, 64'd236489007,
        64'd411620509, 64'd166766312, 64'd361210002, 64'd283644967,
        64'd119641924, 64'd69485002,  64'd377870531, 64'd113980432,
        64'd364456658, 64'd287448779, 64'd141061818, 64'd198138578,
        64'd116842912, 64'd307991489, 64'd201984000, 64'd350364459,
        64'd92809236,  64'd164348060, 64'd148959980, 64'd326501783,
        64'd132148331, 64'd24694032,  64'd34476500,  64'd274413237,
        64'd164035902, 64'd11016039,  64'd329087019, 64'd194669370,
        64'd190407088, 64'd121086105, 64'd26299711,  64'd367248076,
        64'd92649296,  64'd79189179,  64'd256366023, 64'd204156770,
        64'd2324851,   64'd391323303, 64'd102893852, 64'd11160450
    };

    // one xorshift-star mixing step
    function automatic logic [WORD_W-1:0] mix_words(
        input logic [WORD_W-1:0] s0_in,
        input logic [WORD_W-1:0] s1_in,
        input logic              sel_large
    );
        logic [WORD_W-1:0] s0;
        logic [WORD_W-1:0] s1;
        s0 = s0_in;
        s1 = s1_in;
        if (sel_large == VAR_LARGE)
        begin
            s1 = s1 ^ (s1 << LARGE_A);
            s1 = s1 ^ (s1 >> LARGE_B);
            s0 = s0 ^ (s0 >> LARGE_C);
        end
        else
        begin
            s1 = s1 ^ (s1 << SMALL_A);
            s1 = s1 ^ (s1 >> SMALL_B);
            s0 = s0 ^ (s0 >> SMALL_C);
        end
        return s0 ^ s1;
    endfunction

endpackage

/* rtl/xorshift_star_prng.sv */
// ---------------------------------------------------------------------------
// xorshift_star_prng
// xorshift1024* / xorshift4096* generator over a shared 64-word seed store
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: tuser is the opcode (draw or
//   seed load), tdata holds the seed index and seed value of a load.
//   A draw gives one 64-bit result on m_axis; a load gives none.
//   cfg_wr_en/cfg_index/cfg_data write variant and the two multipliers;
//   the user must write only while the block is idle; the block does not enforce this.
// Pipeline:
//   one item accepted per cycle while s_axis_tready is high; a draw passes
//   mix and write-back, partial products and final sum before it shows on
//   m_axis (the store is read at the accepting edge). The store is read at
//   two ports and written back from stage 1, with a forwarding path so
//   back-to-back draws see the newest word. The 64x64 product is split
//   into 32x32 partial products over two stages.
// Reset:
//   pointers clear, registers take their default values, and the store
//   reads as the default seed table through per-word valid bits, so there
//   is no clearing pass and items are taken from the first cycle.
// Stall:
//   when m_axis_tready is low the result holds; earlier stages fill their
//   bubbles, then s_axis_tready drops. Loads drain even while stalled.
// ---------------------------------------------------------------------------
`include "xorshift_star_prng_assert.svh"

module xorshift_star_prng (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [5:0] seed_index, [69:6] seed_value, rest zero
    input  logic        s_axis_tuser,   // [0] opcode
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] random_value
);

    localparam int AW = xsp_pkg::ADDR_W;
    localparam int WW = xsp_pkg::WORD_W;
    localparam int HW = xsp_pkg::HALF_W;
    localparam int SW = xsp_pkg::SMALL_W;

    // configuration registers
    logic          variant_reg;
    logic [WW-1:0] mult_small_reg;
    logic [WW-1:0] mult_large_reg;

    // generator pointers
    logic [SW-1:0] ptr_small_reg;
    logic [AW-1:0] ptr_large_reg;
    logic [SW-1:0] ptr_small_next;
    logic [AW-1:0] ptr_large_next;

    // seed store and its valid bits
    logic [WW-1:0]          store_mem [xsp_pkg::STORE_WORDS];
    logic [xsp_pkg::STORE_WORDS-1:0] store_vld_reg;

    // stage 1: read data and item fields
    logic          s1_valid_reg;
    logic          s1_load_reg;
    logic          s1_var_reg;
    logic [AW-1:0] s1_a0_reg;
    logic [AW-1:0] s1_a1_reg;
    logic [5:0]    s1_idx_reg;
    logic [WW-1:0] s1_value_reg;
    logic [WW-1:0] s1_q0_reg;
    logic [WW-1:0] s1_q1_reg;
    logic          s1_v0_reg;
    logic          s1_v1_reg;
    logic          s1_f0_reg;
    logic          s1_f1_reg;
    logic [WW-1:0] s1_fdata_reg;

    // stage 2: new state word and multiplier
    logic          s2_valid_reg;
    logic [WW-1:0] s2_word_reg;
    logic [WW-1:0] s2_mult_reg;

    // stage 3: partial products
    logic          s3_valid_reg;
    logic [WW-1:0] s3_p0_reg;
    logic [HW-1:0] s3_p1_reg;
    logic [HW-1:0] s3_p2_reg;

    // stage 4: result register
    logic          out_valid_reg;
    logic [WW-1:0] out_data_reg;

    // handshake and flow
    logic          accept;
    logic          in_draw;
    logic [5:0]    in_idx;
    logic [WW-1:0] in_value;
    logic [AW-1:0] rd_a0;
    logic [AW-1:0] rd_a1;
    logic          en1;
    logic          mv1;
    logic          en2;
    logic          en3;
    logic          en4;

    // mix and write-back
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic [WW-1:0] s0_word;
    logic [WW-1:0] s1_word;
    logic [WW-1:0] mix_word;
    logic          load_ok;

    assign in_draw  = (s_axis_tuser == xsp_pkg::OP_DRAW);
    assign in_idx   = s_axis_tdata[5:0];
    assign in_value = s_axis_tdata[69:6];

    // stage enables, each stage moves when the next one is free or moving
    assign en4 = !out_valid_reg || m_axis_tready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign mv1 = s1_valid_reg && (s1_load_reg || en2);
    assign en1 = !s1_valid_reg || mv1;

    assign s_axis_tready = en1;
    assign accept        = s_axis_tvalid && en1;

    // pointer advance
    always_comb
    begin
        ptr_small_next = ptr_small_reg + 1'b1;
        if (ptr_large_reg == AW'(xsp_pkg::STORE_WORDS - 1))
        begin
            ptr_large_next = '0;
        end
        else
        begin
            ptr_large_next = ptr_large_reg + 1'b1;
        end
    end

    // read addresses for the item at the input
    always_comb
    begin
        if (variant_reg == xsp_pkg::VAR_LARGE)
        begin
            rd_a0 = ptr_large_reg;
            rd_a1 = ptr_large_next;
        end
        else
        begin
            rd_a0 = AW'(ptr_small_reg);
            rd_a1 = AW'(ptr_small_next);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg    <= xsp_pkg::VAR_SMALL;
            mult_small_reg <= xsp_pkg::MULT_SMALL_RST;
            mult_large_reg <= xsp_pkg::MULT_LARGE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                xsp_pkg::CFG_VARIANT:    variant_reg    <= cfg_data[0];
                xsp_pkg::CFG_MULT_SMALL: mult_small_reg <= cfg_data;
                xsp_pkg::CFG_MULT_LARGE: mult_large_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pointers move when a draw is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_small_reg <= '0;
            ptr_large_reg <= '0;
        end
        else if (accept && in_draw)
        begin
            if (variant_reg == xsp_pkg::VAR_LARGE)
            begin
                ptr_large_reg <= ptr_large_next;
            end
            else
            begin
                ptr_small_reg <= ptr_small_next;
            end
        end
    end

    // store: two registered reads at accept, one write from stage 1
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            s1_q0_reg <= store_mem[rd_a0];
            s1_q1_reg <= store_mem[rd_a1];
        end
    end

    // valid bits: an unwritten word reads as its default seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            store_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // stage 1 payload, with forwarding of the write at the same edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg  <= !in_draw;
            s1_var_reg   <= variant_reg;
            s1_a0_reg    <= rd_a0;
            s1_a1_reg    <= rd_a1;
            s1_idx_reg   <= in_idx;
            s1_value_reg <= in_value;
            s1_v0_reg    <= store_vld_reg[rd_a0];
            s1_v1_reg    <= store_vld_reg[rd_a1];
            s1_f0_reg    <= wr_en && (wr_addr == rd_a0);
            s1_f1_reg    <= wr_en && (wr_addr == rd_a1);
            s1_fdata_reg <= wr_data;
        end
    end

    // state words seen by the item in stage 1
    always_comb
    begin
        if (s1_f0_reg)
        begin
            s0_word = s1_fdata_reg;
        end
        else if (s1_v0_reg)
        begin
            s0_word = s1_q0_reg;
        end
        else
        begin
            s0_word = xsp_pkg::DEFAULT_SEEDS[s1_a0_reg];
        end

        if (s1_f1_reg)
        begin
            s1_word = s1_fdata_reg;
        end
        else if (s1_v1_reg)
        begin
            s1_word = s1_q1_reg;
        end
        else
        begin
            s1_word = xsp_pkg::DEFAULT_SEEDS[s1_a1_reg];
        end
    end

    assign mix_word = xsp_pkg::mix_words(s0_word, s1_word, s1_var_reg);
    assign load_ok  = ({1'b0, s1_idx_reg} < 7'(xsp_pkg::STORE_WORDS));

    // write-back of a draw, or the seed word of a load
    always_comb
    begin
        if (s1_load_reg)
        begin
            wr_en   = mv1 && load_ok;
            wr_addr = AW'(s1_idx_reg);
            wr_data = s1_value_reg;
        end
        else
        begin
            wr_en   = mv1;
            wr_addr = s1_a1_reg;
            wr_data = mix_word;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                s2_valid_reg <= mv1 && !s1_load_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 2: new word and the variant's multiplier
    always_ff @(posedge clk)
    begin
        if (en2 && mv1 && !s1_load_reg)
        begin
            s2_word_reg <= mix_word;
            s2_mult_reg <= (s1_var_reg == xsp_pkg::VAR_LARGE) ? mult_large_reg
                                                               : mult_small_reg;
        end
    end

    // stage 3: 32x32 partial products of the low 64 bits
    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_p0_reg <= WW'(s2_word_reg[HW-1:0]) * WW'(s2_mult_reg[HW-1:0]);
            s3_p1_reg <= s2_word_reg[HW-1:0] * s2_mult_reg[WW-1:HW];
            s3_p2_reg <= s2_word_reg[WW-1:HW] * s2_mult_reg[HW-1:0];
        end
    end

    // stage 4: final sum into the result register
    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            out_data_reg <= s3_p0_reg + {s3_p1_reg + s3_p2_reg, {HW{1'b0}}};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // input is refused only behind a draw that cannot move on
    `XSP_ASSERT_IMPL(a_ready_blocked, !s_axis_tready,
        s1_valid_reg && !s1_load_reg && !en2, "input stalled without a blocked draw")

    // small generator reads neighboring words inside the first sixteen
    `XSP_ASSERT_IMPL(a_small_addr, s1_valid_reg && !s1_load_reg &&
        (s1_var_reg == xsp_pkg::VAR_SMALL),
        (s1_a1_reg[SW-1:0] == s1_a0_reg[SW-1:0] + 1'b1) && (s1_a1_reg[AW-1:SW] == '0),
        "small generator address slip")

    // a small draw advances its pointer by one
    `XSP_ASSERT_NEXT(a_small_ptr, accept && in_draw &&
        (variant_reg == xsp_pkg::VAR_SMALL),
        ptr_small_reg == $past(ptr_small_reg) + 1'b1, "small pointer did not advance")

    // a result appears only from a filled product stage
    `XSP_ASSERT_IMPL(a_out_source, $rose(out_valid_reg), $past(s3_valid_reg),
        "result without a product in flight")

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// xorshift_star_prng testbench
// Drives draw and seed-load items into the generator over its input
// stream. A mirror of the seed store, both pointers and the registers
// predicts every random value. Results are compared in order as they leave
// the output stream. Configuration changes only while the pipeline is
// empty. Both stream sides idle at random, and the output is held off once
// for long enough that the input stalls.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 60;
    localparam int GAP_PCT       = 21;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam logic [xsp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // [5:0] seed_index, [69:6] seed_value, rest zero
    logic        s_axis_tuser;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] random_value

    // mirror of the generator state
    logic [xsp_pkg::WORD_W-1:0]  seed_store [xsp_pkg::STORE_WORDS];
    logic [xsp_pkg::SMALL_W-1:0] small_ptr;
    logic [xsp_pkg::ADDR_W-1:0]  large_ptr;
    logic                        variant_sel;
    logic [xsp_pkg::WORD_W-1:0]  small_mult;
    logic [xsp_pkg::WORD_W-1:0]  large_mult;

    logic [xsp_pkg::WORD_W-1:0] expected_randoms [$];
    logic [xsp_pkg::WORD_W-1:0] want_random;
    int                         error_count;
    bit                         no_gaps;
    bit                         hold_req;

    xorshift_star_prng uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (no_gaps)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= GAP_PCT);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_randoms.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want_random = expected_randoms.pop_front();
                if (m_axis_tdata !== want_random)
                begin
                    error_count++;
                    $display("%0t: random_value mismatch, expected %h, actual %h",
                             $time, want_random, m_axis_tdata);
                end
            end
        end
    end

    // one xorshift-star step on the mirror; draws queue the expected value
    task automatic predict_item(input logic op, input logic [xsp_pkg::ADDR_W-1:0] idx,
                                input logic [xsp_pkg::WORD_W-1:0] val);
        logic [xsp_pkg::ADDR_W-1:0] cur;
        logic [xsp_pkg::ADDR_W-1:0] nxt;
        logic [xsp_pkg::WORD_W-1:0] w0;
        logic [xsp_pkg::WORD_W-1:0] w1;
        logic [xsp_pkg::WORD_W-1:0] mult;
        if (op == xsp_pkg::OP_LOAD)
        begin
            seed_store[idx] = val;
            return;
        end
        if (variant_sel == xsp_pkg::VAR_SMALL)
        begin
            cur = xsp_pkg::ADDR_W'(small_ptr);
            small_ptr = small_ptr + 1'b1;
            nxt = xsp_pkg::ADDR_W'(small_ptr);
            w0 = seed_store[cur];
            w1 = seed_store[nxt];
            w1 = w1 ^ (w1 << xsp_pkg::SMALL_A);
            w1 = w1 ^ (w1 >> xsp_pkg::SMALL_B);
            w0 = w0 ^ (w0 >> xsp_pkg::SMALL_C);
            mult = small_mult;
        end
        else
        begin
            cur = large_ptr;
            large_ptr = large_ptr + 1'b1;
            nxt = large_ptr;
            w0 = seed_store[cur];
            w1 = seed_store[nxt];
            w1 = w1 ^ (w1 << xsp_pkg::LARGE_A);
            w1 = w1 ^ (w1 >> xsp_pkg::LARGE_B);
            w0 = w0 ^ (w0 >> xsp_pkg::LARGE_C);
            mult = large_mult;
        end
        seed_store[nxt] = w0 ^ w1;
        expected_randoms.push_back(seed_store[nxt] * mult);
    endtask

    // offer one item until it is taken
    task automatic send_item(input logic op, input logic [xsp_pkg::ADDR_W-1:0] idx,
                             input logic [xsp_pkg::WORD_W-1:0] val);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, val, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_item(op, idx, val);
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // random item; draw_pct sets the share of draws
    task automatic random_item(input int draw_pct);
        logic op;
        if (!no_gaps && $urandom_range(99) < GAP_PCT)
            pause_input(1);
        op = ($urandom_range(99) < draw_pct) ? xsp_pkg::OP_DRAW : xsp_pkg::OP_LOAD;
        send_item(op, xsp_pkg::ADDR_W'($urandom), {$urandom, $urandom});
    endtask

    // empty pipeline, including loads still in flight
    task automatic drain;
        pause_input(1);
        while (expected_randoms.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [xsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == xsp_pkg::CFG_VARIANT)
            variant_sel = val[0];
        else if (idx == xsp_pkg::CFG_MULT_SMALL)
            small_mult = val;
        else if (idx == xsp_pkg::CFG_MULT_LARGE)
            large_mult = val;
    endtask

    // reset defaults, field extremes, ignored seed fields on draws
    task automatic test_directed;
        send_item(xsp_pkg::OP_DRAW, '0, '0);
        send_item(xsp_pkg::OP_DRAW, '1, '1);
        send_item(xsp_pkg::OP_LOAD, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(xsp_pkg::OP_LOAD, 6'd63, 64'h0);
        send_item(xsp_pkg::OP_LOAD, 6'h2A, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(xsp_pkg::OP_LOAD, 6'h15, 64'h5555_5555_5555_5555);
        send_item(xsp_pkg::OP_LOAD, 6'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(xsp_pkg::OP_DRAW, 6'h2A, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(xsp_pkg::OP_DRAW, 6'h15, 64'h5555_5555_5555_5555);
        drain();
        // the unused register index must not disturb anything
        write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(xsp_pkg::CFG_VARIANT, {63'h0, xsp_pkg::VAR_LARGE});
        send_item(xsp_pkg::OP_DRAW, '0, '0);
        send_item(xsp_pkg::OP_DRAW, '0, '0);
        send_item(xsp_pkg::OP_LOAD, 6'd1, 64'h8000_0000_0000_0001);
        send_item(xsp_pkg::OP_DRAW, '1, '1);
        drain();
        write_reg(xsp_pkg::CFG_MULT_SMALL, 64'h0);
        write_reg(xsp_pkg::CFG_MULT_LARGE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(xsp_pkg::OP_DRAW, '0, '0);
        drain();
        write_reg(xsp_pkg::CFG_VARIANT, {63'h0, xsp_pkg::VAR_SMALL});
        send_item(xsp_pkg::OP_DRAW, '0, '0);
        drain();
        write_reg(xsp_pkg::CFG_MULT_SMALL, 64'h1);
        write_reg(xsp_pkg::CFG_MULT_LARGE, 64'h1);
        send_item(xsp_pkg::OP_DRAW, '0, '0);
        drain();
    endtask

    // all-zero small area keeps producing zero, across a pointer wrap
    task automatic test_zero_store;
        write_reg(xsp_pkg::CFG_VARIANT, {63'h0, xsp_pkg::VAR_SMALL});
        write_reg(xsp_pkg::CFG_MULT_SMALL, xsp_pkg::MULT_SMALL_RST);
        for (int i = 0; i < 16; i++)
            send_item(xsp_pkg::OP_LOAD, xsp_pkg::ADDR_W'(i), 64'h0);
        repeat (20)
            send_item(xsp_pkg::OP_DRAW, xsp_pkg::ADDR_W'($urandom), {$urandom, $urandom});
        drain();
    endtask

    // random phases, each with its own register setting
    task automatic test_random;
        logic [63:0] ms;
        logic [63:0] ml;
        for (int phase = 0; phase < 7; phase++)
        begin
            unique case (phase)
                0: begin ms = 64'h0; ml = 64'hFFFF_FFFF_FFFF_FFFF; end
                1: begin ms = 64'hFFFF_FFFF_FFFF_FFFF; ml = 64'h0; end
                2: begin ms = xsp_pkg::MULT_SMALL_RST; ml = xsp_pkg::MULT_LARGE_RST; end
                default: begin ms = {$urandom, $urandom}; ml = {$urandom, $urandom}; end
            endcase
            write_reg(xsp_pkg::CFG_VARIANT, {$urandom, 31'($urandom), phase[0] ^ phase[2]});
            write_reg(xsp_pkg::CFG_MULT_SMALL, ms);
            write_reg(xsp_pkg::CFG_MULT_LARGE, ml);
            // one phase runs with no idling on either side
            no_gaps = (phase == 3);
            repeat (70) random_item(75);
            no_gaps = 1'b0;
            drain();
        end
    endtask

    // long output hold-off while draws keep coming
    task automatic test_backpressure;
        write_reg(xsp_pkg::CFG_VARIANT, {63'h0, 1'($urandom)});
        hold_req = 1'b1;
        repeat (40)
            send_item(xsp_pkg::OP_DRAW, xsp_pkg::ADDR_W'($urandom), {$urandom, $urandom});
        repeat (10) random_item(50);
        drain();
    endtask

    // main sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = xsp_pkg::OP_DRAW;
        s_axis_tdata  = '0;
        error_count   = 0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        for (int i = 0; i < xsp_pkg::STORE_WORDS; i++)
            seed_store[i] = xsp_pkg::DEFAULT_SEEDS[i];
        small_ptr   = '0;
        large_ptr   = '0;
        variant_sel = xsp_pkg::VAR_SMALL;
        small_mult  = xsp_pkg::MULT_SMALL_RST;
        large_mult  = xsp_pkg::MULT_LARGE_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_zero_store();
        test_random();
        test_backpressure();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
